/* design/wrs_pkg.sv */
// Shared constants for the win-ratio sorter.
// No dependencies; compile first.
`default_nettype none

package wrs_pkg;

	// fixed field widths of the channel words
	localparam int ID_BITS   = 4;
	localparam int WORD_BITS = 16;

endpackage

`default_nettype wire

/* design/wrs_in_if.sv */
// Input channel of the win-ratio sorter: valid/ready plus one count pair.
// Depends on wrs_pkg.
`default_nettype none

interface wrs_in_if
	import wrs_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] wins;
	logic [WORD_BITS-1:0] appearances;

	modport source (output valid, output wins, output appearances, input ready);
	modport sink   (input valid, input wins, input appearances, output ready);
endinterface

`default_nettype wire

/* design/wrs_out_if.sv */
// Output channel of the win-ratio sorter: valid/ready plus one ranked entry.
// Depends on wrs_pkg.
`default_nettype none

interface wrs_out_if
	import wrs_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [ID_BITS-1:0]   entry_id;
	logic [WORD_BITS-1:0] wins_res;
	logic [WORD_BITS-1:0] appearances_res;
	logic                 no_rate;
	logic                 last;

	modport source (output valid, output entry_id, output wins_res,
		output appearances_res, output no_rate, output last, input ready);
	modport sink   (input valid, input entry_id, input wins_res,
		input appearances_res, input no_rate, input last, output ready);
endinterface

`default_nettype wire

/* design/wrs_cell.sv */
// One cell of the systolic insertion chain: holds one entry, compares the
// word arriving from the left and passes the larger one right. Uses wrs_pkg.
`default_nettype none

module wrs_cell
	import wrs_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  shift,
	// word from the left neighbor
	input  wire logic                  pv_in,
	input  wire logic                  pd_in,
	input  wire logic [COUNT_BITS-1:0] pw_in,
	input  wire logic [COUNT_BITS-1:0] pa_in,
	input  wire logic [ID_BITS-1:0]    pid_in,
	// held entry of the right neighbor, used while unloading
	input  wire logic                  rv_in,
	input  wire logic [COUNT_BITS-1:0] rw_in,
	input  wire logic [COUNT_BITS-1:0] ra_in,
	input  wire logic [ID_BITS-1:0]    rid_in,
	// word passed to the right neighbor
	output logic                       pv_out,
	output logic                       pd_out,
	output logic [COUNT_BITS-1:0]      pw_out,
	output logic [COUNT_BITS-1:0]      pa_out,
	output logic [ID_BITS-1:0]         pid_out,
	// held entry
	output logic                       hv_out,
	output logic [COUNT_BITS-1:0]      hw_out,
	output logic [COUNT_BITS-1:0]      ha_out,
	output logic [ID_BITS-1:0]         hid_out
);
	logic                      hv_q;
	logic [COUNT_BITS-1:0]     hw_q;
	logic [COUNT_BITS-1:0]     ha_q;
	logic [ID_BITS-1:0]        hid_q;
	logic                      pv_q;
	logic                      pd_q;
	logic [COUNT_BITS-1:0]     pw_q;
	logic [COUNT_BITS-1:0]     pa_q;
	logic [ID_BITS-1:0]        pid_q;
	logic [2*COUNT_BITS-1:0]   held_prod;
	logic [2*COUNT_BITS-1:0]   in_prod;
	logic                      held_gt;
	logic                      take;

	// exact ratio compare: held.w / held.a > in.w / in.a
	assign held_prod = {{COUNT_BITS{1'b0}}, hw_q} * {{COUNT_BITS{1'b0}}, pa_in};
	assign in_prod   = {{COUNT_BITS{1'b0}}, pw_in} * {{COUNT_BITS{1'b0}}, ha_q};
	// no-rate held entries never outrank; a no-rate incoming word loses to any rated one
	assign held_gt = (ha_q != '0) && ((pa_in == '0) || (held_prod > in_prod));
	// a word displaced from the left ranks before every entry held to its right:
	// shift it in unconditionally so equal keys keep their load order
	assign take = !hv_q || pd_in || held_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			pv_q <= 1'b0;
			pd_q <= 1'b0;
		end else if (shift) begin
			hv_q <= rv_in;
			pv_q <= 1'b0;
			pd_q <= 1'b0;
		end else if (pv_in) begin
			hv_q <= 1'b1;
			pv_q <= hv_q;
			pd_q <= hv_q && take;
		end else begin
			pv_q <= 1'b0;
			pd_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			hw_q  <= rw_in;
			ha_q  <= ra_in;
			hid_q <= rid_in;
		end else if (pv_in) begin
			if (take) begin
				// take the incoming word, push the held one right
				hw_q  <= pw_in;
				ha_q  <= pa_in;
				hid_q <= pid_in;
				pw_q  <= hw_q;
				pa_q  <= ha_q;
				pid_q <= hid_q;
			end else begin
				pw_q  <= pw_in;
				pa_q  <= pa_in;
				pid_q <= pid_in;
			end
		end
	end

	assign pv_out  = pv_q;
	assign pd_out  = pd_q;
	assign pw_out  = pw_q;
	assign pa_out  = pa_q;
	assign pid_out = pid_q;
	assign hv_out  = hv_q;
	assign hw_out  = hw_q;
	assign ha_out  = ha_q;
	assign hid_out = hid_q;

endmodule

`default_nettype wire

/* design/win_ratio_sorter_unit.sv */
// Top level of the win-ratio sorter: load counter, chain of wrs_cell,
// settle/unload sequencer and output register. Uses wrs_pkg and both channels.
//
// Usage:
//   items  (sink)   : one word per entry, wins and appearances. ENTRIES words
//                     make a run; they are taken at one word per cycle.
//   ranks  (source) : after the run's last word, ENTRIES words in ascending
//                     order of wins/appearances (no-rate entries lowest, ties
//                     in load order), last set on the final word.
// Each loaded word walks right through the cell chain one cell per cycle, so
// after the final load the chain must settle before it unloads. The chain
// then unloads from its left end, one word per cycle while ranks is taken.
// items.ready is low from the final load until the last word enters the
// output register; a stalled receiver simply holds the unload. The next run
// can load while that last word waits. Reset empties the chain and the
// output register, restarts the load count and returns to loading; the data
// registers are not cleared.
`default_nettype none

module win_ratio_sorter_unit
	import wrs_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wrs_in_if.sink     items,
	wrs_out_if.source  ranks
);
	localparam int CNT_W = $clog2(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

	localparam logic [1:0] ST_LOAD   = 2'd0;
	localparam logic [1:0] ST_SETTLE = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             step;
	logic             shift;
	logic             cnt_end;

	logic                  ov_q;
	logic [ID_BITS-1:0]    oid_q;
	logic [WORD_BITS-1:0]  ow_q;
	logic [WORD_BITS-1:0]  oa_q;
	logic                  onr_q;
	logic                  olast_q;

	// chain wiring: index i is the word entering cell i from the left
	logic                  pv  [ENTRIES+1];
	logic                  pd  [ENTRIES+1];
	logic [COUNT_BITS-1:0] pw  [ENTRIES+1];
	logic [COUNT_BITS-1:0] pa  [ENTRIES+1];
	logic [ID_BITS-1:0]    pid [ENTRIES+1];
	// held entries; index ENTRIES is the empty slot past the right end
	logic                  hv  [ENTRIES+1];
	logic [COUNT_BITS-1:0] hw  [ENTRIES+1];
	logic [COUNT_BITS-1:0] ha  [ENTRIES+1];
	logic [ID_BITS-1:0]    hid [ENTRIES+1];

	assign items.ready = (state_q == ST_LOAD);
	assign accept      = items.valid && items.ready;
	assign cnt_end     = (cnt_q == CNT_LAST);
	assign step        = !ov_q || ranks.ready;
	assign shift       = (state_q == ST_DRAIN) && step;

	assign pv[0]  = accept;
	assign pd[0]  = 1'b0;
	assign pw[0]  = COUNT_BITS'(items.wins);
	assign pa[0]  = COUNT_BITS'(items.appearances);
	assign pid[0] = ID_BITS'(cnt_q);

	assign hv[ENTRIES]  = 1'b0;
	assign hw[ENTRIES]  = '0;
	assign ha[ENTRIES]  = '0;
	assign hid[ENTRIES] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		wrs_cell #(
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.pv_in   (pv[i]),
			.pd_in   (pd[i]),
			.pw_in   (pw[i]),
			.pa_in   (pa[i]),
			.pid_in  (pid[i]),
			.rv_in   (hv[i+1]),
			.rw_in   (hw[i+1]),
			.ra_in   (ha[i+1]),
			.rid_in  (hid[i+1]),
			.pv_out  (pv[i+1]),
			.pd_out  (pd[i+1]),
			.pw_out  (pw[i+1]),
			.pa_out  (pa[i+1]),
			.pid_out (pid[i+1]),
			.hv_out  (hv[i]),
			.hw_out  (hw[i]),
			.ha_out  (ha[i]),
			.hid_out (hid[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
						if (cnt_end) begin
							state_q <= ST_SETTLE;
						end
					end
				end
				ST_SETTLE: begin
					cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
					if (cnt_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (step) begin
						cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
						if (cnt_end) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// output register: advance on unload, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (shift) begin
			ov_q <= 1'b1;
		end else if (ranks.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			oid_q   <= hid[0];
			ow_q    <= WORD_BITS'(hw[0]);
			oa_q    <= WORD_BITS'(ha[0]);
			onr_q   <= (ha[0] == '0);
			olast_q <= cnt_end;
		end
	end

	assign ranks.valid           = ov_q;
	assign ranks.entry_id        = oid_q;
	assign ranks.wins_res        = ow_q;
	assign ranks.appearances_res = oa_q;
	assign ranks.no_rate         = onr_q;
	assign ranks.last            = olast_q;

endmodule

`default_nettype wire

/* design/wrs_checker.sv */
// Port-level checks for win_ratio_sorter_unit, bound to every instance.
// Sees only the top level's ports; no package dependency.
`default_nettype none

module wrs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  out_id,
	input wire logic [15:0] out_wins,
	input wire logic [15:0] out_apps,
	input wire logic        out_no_rate,
	input wire logic        out_last
);
	// a waiting word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_id)
			&& $stable(out_wins) && $stable(out_apps) && $stable(out_last)))
		else $error("stalled output word changed");

	a_no_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_no_rate == (out_apps == 16'd0)))
		else $error("no_rate disagrees with appearance count");

	// loading stops only after a run's final word is taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input ready dropped without an accepted word");

	// loading resumes exactly when the run's last ranked word is presented
	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> (out_valid && out_last))
		else $error("input ready rose before the last ranked word");
endmodule

bind win_ratio_sorter_unit wrs_checker u_wrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (items.valid),
	.in_ready    (items.ready),
	.out_valid   (ranks.valid),
	.out_ready   (ranks.ready),
	.out_id      (ranks.entry_id),
	.out_wins    (ranks.wins_res),
	.out_apps    (ranks.appearances_res),
	.out_no_rate (ranks.no_rate),
	.out_last    (ranks.last)
);

`default_nettype wire

/* tb/tb_win_ratio_sorter_unit.sv */
// Self-checking bench for win_ratio_sorter_unit: loads 16-word runs and checks the ranked words.
// A local predictor does the stable ascending sort by exact cross-multiplied rate.
// Depends on wrs_pkg, wrs_in_if, wrs_out_if and the sorter RTL.
`default_nettype none

module tb_win_ratio_sorter_unit
	import wrs_pkg::*;
();

	localparam int ENTRIES       = 16;
	localparam int COUNT_BITS    = 16;
	localparam int RANDOM_RUNS   = 18;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
	localparam int CYCLE_LIMIT   = 100000;

	typedef logic [WORD_BITS-1:0] count_t;

	typedef struct packed {
		count_t             wins;
		count_t             appearances;
		logic [ID_BITS-1:0] id;
	} tally_t;

	typedef struct packed {
		logic [ID_BITS-1:0] entry_id;
		count_t             wins_res;
		count_t             appearances_res;
		logic               no_rate;
		logic               last;
	} rank_t;

	// stimulus word of the opening run; want is the run's output at the same rank
	typedef struct packed {
		count_t wins;
		count_t appearances;
		logic   typed;
		rank_t  want;
	} probe_t;

	localparam rank_t NO_RANK = '0;

	// sorted order of this run: 0,1,14,2,3,4,7,5,6,8,9,10,11,15,12,13
	localparam probe_t PROBES [ENTRIES] = '{
		'{16'd0,     16'd0,     1'b1, '{4'd0,  16'd0,     16'd0, 1'b1, 1'b0}},
		'{16'd65535, 16'd0,     1'b1, '{4'd1,  16'd65535, 16'd0, 1'b1, 1'b0}},
		'{16'd0,     16'd65535, 1'b1, '{4'd14, 16'd0,     16'd0, 1'b1, 1'b0}},
		'{16'd0,     16'd1,     1'b0, NO_RANK},
		'{16'd1,     16'd65535, 1'b0, NO_RANK},
		'{16'd1,     16'd2,     1'b0, NO_RANK},
		'{16'd2,     16'd4,     1'b0, NO_RANK},
		'{16'd32767, 16'd65535, 1'b0, NO_RANK},
		'{16'd32768, 16'd65535, 1'b0, NO_RANK},
		'{16'd65534, 16'd65535, 1'b0, NO_RANK},
		'{16'd3,     16'd3,     1'b0, NO_RANK},
		'{16'd65535, 16'd65535, 1'b0, NO_RANK},
		'{16'd65535, 16'd65534, 1'b0, NO_RANK},
		'{16'd65535, 16'd1,     1'b0, NO_RANK},
		'{16'd0,     16'd0,     1'b0, NO_RANK},
		'{16'd1,     16'd1,     1'b1, '{4'd13, 16'd65535, 16'd1, 1'b0, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	wrs_in_if  items ();
	wrs_out_if ranks ();

	win_ratio_sorter_unit #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.items (items),
		.ranks (ranks)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	tally_t run_store [ENTRIES];
	int     loaded_words;
	bit     opening_run = 1'b1;
	rank_t  ranks_due [$];
	rank_t  want_word;
	int     mismatches;
	int     cycle_count;
	int     send_idle_pct = 37;
	int     recv_idle_pct = 63;
	bit     hold_off_pending;

	// exact rate compare; a no-rate entry is never above anything
	function automatic bit rate_above(tally_t a, tally_t b);
		logic [2*WORD_BITS-1:0] lhs;
		logic [2*WORD_BITS-1:0] rhs;
		if (a.appearances == '0)
			return 1'b0;
		if (b.appearances == '0)
			return 1'b1;
		lhs = {{WORD_BITS{1'b0}}, a.wins};
		rhs = {{WORD_BITS{1'b0}}, b.wins};
		lhs = lhs * {{WORD_BITS{1'b0}}, b.appearances};
		rhs = rhs * {{WORD_BITS{1'b0}}, a.appearances};
		return lhs > rhs;
	endfunction

	// store one accepted word; on the run's last word sort and queue its ranks
	task automatic tally_word(input count_t wins, input count_t appearances);
		tally_t swap_slot;
		rank_t  ranked;
		run_store[loaded_words] = '{wins, appearances, loaded_words[ID_BITS-1:0]};
		loaded_words++;
		if (loaded_words == ENTRIES) begin
			for (int pass = 0; pass < ENTRIES - 1; pass++)
				for (int k = 0; k < ENTRIES - 1 - pass; k++)
					if (rate_above(run_store[k], run_store[k+1])) begin
						swap_slot = run_store[k];
						run_store[k] = run_store[k+1];
						run_store[k+1] = swap_slot;
					end
			for (int k = 0; k < ENTRIES; k++) begin
				ranked = '{run_store[k].id, run_store[k].wins, run_store[k].appearances,
					run_store[k].appearances == '0, k == ENTRIES - 1};
				if (opening_run && PROBES[k].typed)
					ranked = PROBES[k].want;
				ranks_due.push_back(ranked);
			end
			loaded_words = 0;
			opening_run = 1'b0;
		end
	endtask

	// offer one word, idling at random first; returns at the accepting edge
	task automatic offer(input count_t wins, input count_t appearances);
		while ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			@(posedge clk);
		end
		items.valid       <= 1'b1;
		items.wins        <= wins;
		items.appearances <= appearances;
		do @(posedge clk); while (!items.ready);
		tally_word(wins, appearances);
	endtask

	// hold the sender until every queued rank word has come out
	task automatic pause_until_drained();
		items.valid <= 1'b0;
		do @(posedge clk); while (ranks_due.size() != 0);
	endtask

	function automatic logic [2*WORD_BITS-1:0] draw_tally();
		count_t w;
		count_t a;
		int     pick;
		pick = $urandom_range(99);
		w = count_t'($urandom_range(0, 65535));
		a = count_t'($urandom_range(0, 65535));
		if (pick < 15)
			a = '0;
		else if (pick < 40) begin
			w = count_t'($urandom_range(0, 3));
			a = count_t'($urandom_range(1, 3));
		end else if (pick < 50)
			a = w;
		else if (pick < 58)
			w = '0;
		else if (pick < 64)
			w = 16'hFFFF;
		return {w, a};
	endfunction

	function automatic void check_field(string name, longint unsigned want,
		longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && ranks.valid && ranks.ready) begin
			if (ranks_due.size() == 0) begin
				$error("rank word with nothing expected: entry_id %0d", ranks.entry_id);
				mismatches++;
			end else begin
				want_word = ranks_due.pop_front();
				check_field("entry_id", want_word.entry_id, ranks.entry_id);
				check_field("wins_res", want_word.wins_res, ranks.wins_res);
				check_field("appearances_res", want_word.appearances_res,
					ranks.appearances_res);
				check_field("no_rate", want_word.no_rate, ranks.no_rate);
				check_field("last", want_word.last, ranks.last);
			end
		end
	end

	// receiver: random ready, with one long hold-off on request
	initial begin
		ranks.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				ranks.ready <= 1'b0;
				hold_off_pending = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			ranks.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("win_ratio_sorter_unit regression: fail");
			$finish;
		end
	end

	initial begin
		logic [2*WORD_BITS-1:0] pair;
		arst_n            <= 1'b0;
		items.valid       <= 1'b0;
		items.wins        <= '0;
		items.appearances <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < ENTRIES; k++)
			offer(PROBES[k].wins, PROBES[k].appearances);

		for (int run = 0; run < RANDOM_RUNS; run++) begin
			if (run == RANDOM_RUNS / 3) begin
				pause_until_drained();
				send_idle_pct = 63;
				recv_idle_pct = 37;
			end
			if (run == 2 * RANDOM_RUNS / 3) begin
				pause_until_drained();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				// stall the output so the next run backs up against the input
				hold_off_pending = 1'b1;
			end
			for (int k = 0; k < ENTRIES; k++) begin
				pair = draw_tally();
				offer(pair[2*WORD_BITS-1:WORD_BITS], pair[WORD_BITS-1:0]);
			end
		end

		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("win_ratio_sorter_unit regression: pass");
		else
			$display("win_ratio_sorter_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
design/wrs_pkg.sv
design/wrs_in_if.sv
design/wrs_out_if.sv
design/wrs_cell.sv
design/win_ratio_sorter_unit.sv
design/wrs_checker.sv
tb/tb_win_ratio_sorter_unit.sv
